[src/fct_pkg.sv]
// Shared types and constants for the FAT cluster table engine.
// Used by every module of the block; no dependencies.
`default_nettype none

package fct_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CL_W          = 28;
    localparam int CC_W          = 12;
    localparam int LIM_W         = ((IDX_W > CC_W) ? IDX_W : CC_W) + 1;

    // FAT32 entry values
    localparam logic [31:0]     EOC_MARK      = 32'h0FFF_FFFF;
    localparam logic [CL_W-1:0] EOC_MIN       = 28'h0FFF_FFF8;
    localparam int              FIRST_CLUSTER = 2;

    // Request queue between front and back (depth a power of two)
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Register indexes on the configuration port
    localparam logic [1:0] REG_CLUSTER_COUNT = 2'd0;
    localparam logic [1:0] REG_SECTORS_PER   = 2'd1;
    localparam logic [1:0] REG_DATA_START    = 2'd2;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_SET    = 2'd1,
        OP_ALLOC  = 2'd2,
        OP_FREE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOK,
        BK_ALLOC,
        BK_FREE_CHK,
        BK_FREE_RD,
        BK_MUL,
        BK_ADD,
        BK_RESP
    } bk_state_t;

    typedef struct packed {
        op_t             op;
        logic [CL_W-1:0] cluster;
        logic [31:0]     entry_value;
        logic            in_range;
    } cmd_t;

    typedef struct packed {
        logic [CC_W-1:0] cluster_count;
        logic [7:0]      clus_sectors;
        logic [31:0]     data_start_sector;
    } cfg_t;

endpackage

`default_nettype wire

[src/fct_front.sv]
// Front end: takes request words, checks the cluster against the table and
// holds one classified command for the queue. Depends on fct_pkg.
`default_nettype none

module fct_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire logic [1:0]      op,
    input  wire logic [27:0]     cluster,
    input  wire logic [31:0]     entry_value,
    input  wire logic            init_done,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output fct_pkg::cmd_t        push_cmd
);
    import fct_pkg::*;

    logic cmd_vld_reg;
    cmd_t cmd_reg;

    // Nothing is taken while the table is being cleared
    assign req_ready  = init_done && (!cmd_vld_reg || push_ready);
    assign push_valid = cmd_vld_reg;
    assign push_cmd   = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
        end
        else if (req_valid && req_ready)
        begin
            cmd_vld_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            cmd_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            cmd_reg.op          <= op_t'(op);
            cmd_reg.cluster     <= cluster;
            cmd_reg.entry_value <= entry_value;
            cmd_reg.in_range    <= (32'(cluster) < 32'(TABLE_ENTRIES));
        end
    end

endmodule

`default_nettype wire

[src/fct_queue.sv]
// Short command queue decoupling the front end from the table engine.
// Depends on fct_pkg for the command type and depth.
`default_nettype none

module fct_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire fct_pkg::cmd_t   push_cmd,
    output logic                 pop_valid,
    input  wire logic            pop,
    output fct_pkg::cmd_t        pop_cmd
);
    import fct_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[src/fct_back.sv]
// Back end: owns the allocation table memory, carries out lookup, set, allocate
// and free-chain commands; all but free map clusters to sectors. Uses fct_pkg.
`default_nettype none

module fct_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire fct_pkg::cfg_t   cfg,
    input  wire logic            q_valid,
    input  wire fct_pkg::cmd_t   q_cmd,
    output logic                 q_pop,
    output logic                 init_done,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output logic [1:0]           status,
    output logic [27:0]          cluster_result,
    output logic [31:0]          sector_address
);
    import fct_pkg::*;

    bk_state_t        state_reg;
    bk_state_t        state_next;

    // Table memory, registered read
    logic [31:0]      table_mem [TABLE_ENTRIES];
    logic [31:0]      rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    // Working registers
    logic [IDX_W-1:0] clr_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CL_W-1:0]  cur_reg;
    logic [LIM_W-1:0] limit_reg;
    logic [31:0]      prod_reg;
    status_t          status_reg;
    logic [CL_W-1:0]  cres_reg;
    logic [31:0]      sec_reg;

    // Output register
    logic             rsp_vld_reg;
    status_t          rsp_status_reg;
    logic [CL_W-1:0]  rsp_cres_reg;
    logic [31:0]      rsp_sec_reg;
    logic             rsp_load;

    logic [LIM_W-1:0] limit_calc;
    logic [LIM_W-1:0] limit_sum;
    logic [LIM_W-1:0] scan_next;
    logic             scan_hit;
    logic             free_end;
    logic             cur_in_range;
    logic [31:0]      cl_offset;

    assign limit_sum    = LIM_W'(cfg.cluster_count) + LIM_W'(FIRST_CLUSTER);
    assign limit_calc   = (limit_sum > LIM_W'(TABLE_ENTRIES)) ? LIM_W'(TABLE_ENTRIES)
                                                              : limit_sum;
    assign scan_next    = LIM_W'(idx_reg) + 1'b1;
    assign scan_hit     = (rd_data_reg[CL_W-1:0] == '0);
    assign free_end     = (cur_reg < CL_W'(FIRST_CLUSTER)) || (cur_reg >= EOC_MIN);
    assign cur_in_range = (32'(cur_reg) < 32'(TABLE_ENTRIES));
    assign cl_offset    = 32'(idx_reg) - 32'(FIRST_CLUSTER);

    assign init_done      = (state_reg != BK_CLEAR);
    assign rsp_valid      = rsp_vld_reg;
    assign status         = rsp_status_reg;
    assign cluster_result = rsp_cres_reg;
    assign sector_address = rsp_sec_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[mem_raddr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR:
            begin
                if (clr_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_LOOKUP: state_next = q_cmd.in_range ? BK_LOOK : BK_RESP;
                        OP_SET:    state_next = q_cmd.in_range ? BK_MUL : BK_RESP;
                        OP_ALLOC:  state_next = (cfg.cluster_count == '0) ? BK_RESP
                                                                          : BK_ALLOC;
                        OP_FREE:   state_next = BK_FREE_CHK;
                        default:   state_next = BK_IDLE;
                    endcase
                end
            end
            BK_LOOK:
            begin
                state_next = BK_MUL;
            end
            BK_ALLOC:
            begin
                priority if (scan_hit)
                begin
                    state_next = BK_MUL;
                end
                else if (scan_next >= limit_reg)
                begin
                    state_next = BK_RESP;
                end
            end
            BK_FREE_CHK:
            begin
                state_next = (free_end || !cur_in_range) ? BK_RESP : BK_FREE_RD;
            end
            BK_FREE_RD:
            begin
                state_next = BK_FREE_CHK;
            end
            BK_MUL:
            begin
                state_next = BK_ADD;
            end
            BK_ADD:
            begin
                state_next = BK_RESP;
            end
            BK_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Memory and handshake controls
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '0;
        mem_raddr = idx_reg;
        q_pop     = 1'b0;
        rsp_load  = 1'b0;
        unique case (state_reg)
            BK_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
            end
            BK_IDLE:
            begin
                q_pop = q_valid;
                if (q_cmd.op == OP_ALLOC)
                begin
                    mem_raddr = IDX_W'(FIRST_CLUSTER);
                end
                else
                begin
                    mem_raddr = q_cmd.cluster[IDX_W-1:0];
                end
                if (q_valid && (q_cmd.op == OP_SET) && q_cmd.in_range)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = q_cmd.cluster[IDX_W-1:0];
                    mem_wdata = q_cmd.entry_value;
                end
            end
            BK_ALLOC:
            begin
                // Next entry is read ahead while this one is checked
                mem_raddr = scan_next[IDX_W-1:0];
                if (scan_hit)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = EOC_MARK;
                end
            end
            BK_FREE_CHK:
            begin
                mem_raddr = cur_reg[IDX_W-1:0];
            end
            BK_FREE_RD:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg[IDX_W-1:0];
            end
            BK_RESP:
            begin
                rsp_load = !rsp_vld_reg || rsp_ready;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_CLEAR;
            clr_reg     <= '0;
            cur_reg     <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == BK_IDLE && q_valid)
            begin
                cur_reg <= q_cmd.cluster;
            end
            else if (state_reg == BK_FREE_RD)
            begin
                cur_reg <= rd_data_reg[CL_W-1:0];
            end
            if (rsp_load)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    status_reg <= ST_OK;
                    cres_reg   <= '0;
                    sec_reg    <= '0;
                    limit_reg  <= limit_calc;
                    if (q_cmd.op == OP_ALLOC)
                    begin
                        idx_reg <= IDX_W'(FIRST_CLUSTER);
                        if (cfg.cluster_count == '0)
                        begin
                            status_reg <= ST_FULL;
                        end
                    end
                    else
                    begin
                        idx_reg <= q_cmd.cluster[IDX_W-1:0];
                        if ((q_cmd.op == OP_LOOKUP || q_cmd.op == OP_SET)
                            && !q_cmd.in_range)
                        begin
                            status_reg <= ST_RANGE;
                        end
                    end
                end
            end
            BK_LOOK:
            begin
                cres_reg <= rd_data_reg[CL_W-1:0];
            end
            BK_ALLOC:
            begin
                priority if (scan_hit)
                begin
                    cres_reg <= CL_W'(idx_reg);
                end
                else if (scan_next >= limit_reg)
                begin
                    status_reg <= ST_FULL;
                end
                else
                begin
                    idx_reg <= scan_next[IDX_W-1:0];
                end
            end
            BK_FREE_CHK:
            begin
                if (!free_end && !cur_in_range)
                begin
                    status_reg <= ST_RANGE;
                end
            end
            BK_MUL:
            begin
                prod_reg <= cl_offset * {24'b0, cfg.clus_sectors};
            end
            BK_ADD:
            begin
                sec_reg <= prod_reg + cfg.data_start_sector;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase

        if (rsp_load)
        begin
            rsp_status_reg <= status_reg;
            rsp_cres_reg   <= cres_reg;
            rsp_sec_reg    <= sec_reg;
        end
    end

endmodule

`default_nettype wire

[src/fat_cluster_table_engine.sv]
// Top level of the FAT cluster table engine: configuration registers and
// the front end, command queue and table engine. Depends on fct_pkg.
//
// Usage
//  - Request channel (req_valid/req_ready): one word carries op, cluster and
//    entry_value. Ops are lookup, set entry, allocate and free chain.
//  - Response channel (rsp_valid/rsp_ready): one word per request, in order,
//    with status, cluster_result and sector_address.
//  - APB port: cluster_count at 0x0, sectors per cluster at 0x4,
//    data_start_sector at 0x8; write only while no request is in flight.
//  - Steps per request: lookup reads the entry, then multiplies and adds to
//    form the sector; set writes the entry, then multiplies and adds; allocate
//    scans from cluster 2 (one entry a cycle, read ahead from the table port),
//    then multiplies and adds if one is free; free chain reads, then clears,
//    each link walked. Out-of-range lookups and sets go straight to response.
//  - One request is in the engine at a time; the front end and a two-word
//    queue take further requests meanwhile, and a finished response sits in
//    the output register so the next request can start while it waits.
//  - Reset: the table is cleared by a sweep over 4096 entries, one a cycle;
//    req_ready stays low until it ends. Registers take their reset values.
//  - A stalled receiver holds the response word; the engine waits in its
//    response step and the queue fills, after which req_ready drops.
`default_nettype none

module fat_cluster_table_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  op,
    input  wire logic [27:0] cluster,
    input  wire logic [31:0] entry_value,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic [1:0]       status,
    output logic [27:0]      cluster_result,
    output logic [31:0]      sector_address
);
    import fct_pkg::*;

    logic [CC_W-1:0] cluster_count_reg;
    logic [7:0]      sectors_per_reg;
    logic [31:0]     data_start_reg;
    cfg_t            cfg;
    logic            cfg_write;
    logic [1:0]      reg_index;

    logic            init_done;
    logic            push_valid;
    logic            push_ready;
    cmd_t            push_cmd;
    logic            q_valid;
    logic            q_pop;
    cmd_t            q_cmd;

    // Configuration port: pready is held high, so no transfer waits
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg <= CC_W'(4094);
            sectors_per_reg   <= 8'd1;
            data_start_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_CLUSTER_COUNT: cluster_count_reg <= pwdata[CC_W-1:0];
                REG_SECTORS_PER:   sectors_per_reg   <= pwdata[7:0];
                REG_DATA_START:    data_start_reg    <= pwdata;
                default:           data_start_reg    <= data_start_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_CLUSTER_COUNT: prdata = 32'(cluster_count_reg);
            REG_SECTORS_PER:   prdata = 32'(sectors_per_reg);
            REG_DATA_START:    prdata = data_start_reg;
            default:           prdata = '0;
        endcase
    end

    assign cfg.cluster_count     = cluster_count_reg;
    assign cfg.clus_sectors      = sectors_per_reg;
    assign cfg.data_start_sector = data_start_reg;

    // Front end: accepts and range-checks request words
    fct_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .op          (op),
        .cluster     (cluster),
        .entry_value (entry_value),
        .init_done   (init_done),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    fct_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    // Table engine and output register
    fct_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop),
        .init_done      (init_done),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .cluster_result (cluster_result),
        .sector_address (sector_address)
    );

endmodule

`default_nettype wire

[tb/fat_cluster_table_engine_tb.sv]
// Self-checking testbench for fat_cluster_table_engine: directed and random request words
// are checked against a behavioural FAT table model kept in step with the block.
// Depends on fct_pkg (op and status codes, register indexes, table constants) and the RTL.
`timescale 1ns / 1ps

module fat_cluster_table_engine_tb;

    import fct_pkg::*;

    // One expected response word
    typedef struct packed {
        status_t     rsp_status;
        logic [27:0] next_cl;
        logic [31:0] sector;
    } fat_resp_t;

    // Clock, reset and block ports. Every input the bench drives starts at a known value.
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid   = 1'b0;
    logic        req_ready;
    logic [1:0]  op          = '0;
    logic [27:0] cluster     = '0;
    logic [31:0] entry_value = '0;
    logic        rsp_valid;
    logic        rsp_ready   = 1'b0;
    logic [1:0]  status;
    logic [27:0] cluster_result;
    logic [31:0] sector_address;

    // Model of the block: table contents and the three registers
    logic [31:0] fat_mirror [0:TABLE_ENTRIES-1];
    logic [11:0] cc_mirror  = 12'd4094;
    logic [7:0]  spc_mirror = 8'd1;
    logic [31:0] dss_mirror = 32'd0;

    // Responses still owed by the block, oldest first
    fat_resp_t expected_fat_responses [$];
    fat_resp_t want;

    // Idle percentages for the two channels
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Tallies
    int mismatch_count = 0;
    int words_sent     = 0;
    int words_checked  = 0;
    int full_count     = 0;
    int range_count    = 0;
    int op_count [4]   = '{0, 0, 0, 0};

    fat_cluster_table_engine i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .op             (op),
        .cluster        (cluster),
        .entry_value    (entry_value),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .cluster_result (cluster_result),
        .sector_address (sector_address)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // Data sector of a cluster, wrapping at 32 bits; clusters 0 and 1 wrap too
    function automatic logic [31:0] data_sector(input logic [27:0] cl);
        return ({4'b0, cl} - 32'd2) * {24'b0, spc_mirror} + dss_mirror;
    endfunction

    // Applies one request word to the model and returns the response it owes
    function automatic fat_resp_t predict_fat_response(input op_t kind, input logic [27:0] cl,
                                                       input logic [31:0] val);
        fat_resp_t   r;
        int          lim;
        int          c;
        int          steps;
        logic        found;
        logic [27:0] cur;
        logic [27:0] nxt;
        r.rsp_status = ST_OK;
        r.next_cl    = '0;
        r.sector     = '0;
        case (kind)
            OP_LOOKUP, OP_SET:
            begin
                if (cl >= TABLE_ENTRIES)
                    r.rsp_status = ST_RANGE;
                else
                begin
                    if (kind == OP_LOOKUP)
                        r.next_cl = fat_mirror[cl[IDX_W-1:0]][27:0];
                    else
                        fat_mirror[cl[IDX_W-1:0]] = val;
                    r.sector = data_sector(cl);
                end
            end
            OP_ALLOC:
            begin
                // Search from cluster 2, below both cluster_count + 2 and the table size
                lim = cc_mirror + FIRST_CLUSTER;
                if (lim > TABLE_ENTRIES)
                    lim = TABLE_ENTRIES;
                found = 1'b0;
                for (c = FIRST_CLUSTER; c < lim && !found; c++)
                begin
                    if (fat_mirror[c][27:0] == '0)
                    begin
                        found       = 1'b1;
                        fat_mirror[c] = EOC_MARK;
                        r.next_cl   = 28'(c);
                        r.sector    = data_sector(r.next_cl);
                    end
                end
                if (!found)
                    r.rsp_status = ST_FULL;
            end
            default:
            begin
                // Free walk: clears links until an end mark, a cluster below 2,
                // or a pointer that leaves the table
                cur   = cl;
                steps = 0;
                while (cur >= FIRST_CLUSTER && cur < EOC_MIN && steps <= TABLE_ENTRIES &&
                       r.rsp_status == ST_OK)
                begin
                    if (cur >= TABLE_ENTRIES)
                        r.rsp_status = ST_RANGE;
                    else
                    begin
                        nxt = fat_mirror[cur[IDX_W-1:0]][27:0];
                        fat_mirror[cur[IDX_W-1:0]] = '0;
                        cur = nxt;
                        steps++;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] expected_reg_value(input logic [1:0] idx);
        case (idx)
            REG_CLUSTER_COUNT: return {20'b0, cc_mirror};
            REG_SECTORS_PER:   return {24'b0, spc_mirror};
            default:           return dss_mirror;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers (all entered and left on a rising edge)
    // ------------------------------------------------------------------

    // One APB transfer: setup cycle, then access until pready
    task automatic apb_access(input logic [1:0] idx, input logic wr, input logic [31:0] data,
                              output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_fat_register(input logic [1:0] idx);
        logic [31:0] rd;
        apb_access(idx, 1'b0, '0, rd);
        if (rd !== expected_reg_value(idx))
        begin
            $display("%0t: register %0d read back: expected %h, actual %h",
                     $time, idx, expected_reg_value(idx), rd);
            mismatch_count++;
        end
    endtask

    // Register write, mirrored at the register's own width, then read back
    task automatic write_fat_register(input logic [1:0] idx, input logic [31:0] data);
        logic [31:0] rd;
        apb_access(idx, 1'b1, data, rd);
        case (idx)
            REG_CLUSTER_COUNT: cc_mirror  = data[11:0];
            REG_SECTORS_PER:   spc_mirror = data[7:0];
            REG_DATA_START:    dss_mirror = data;
            default:           dss_mirror = dss_mirror;
        endcase
        check_fat_register(idx);
    endtask

    // Sends one request word. valid stays high between back-to-back words;
    // it only drops when a gap is taken or when sending stops to drain.
    task automatic send_word(input op_t kind, input logic [27:0] cl, input logic [31:0] val,
                             output fat_resp_t predicted);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        req_valid   <= 1'b1;
        op          <= kind;
        cluster     <= cl;
        entry_value <= val;
        do @(posedge clk); while (!req_ready);
        predicted = predict_fat_response(kind, cl, val);
        expected_fat_responses.push_back(predicted);
        op_count[kind]++;
        words_sent++;
    endtask

    // Stop sending and let every owed response come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_fat_responses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure_table(input logic [31:0] cc, input logic [31:0] spc,
                                   input logic [31:0] dss);
        wait_drained();
        write_fat_register(REG_CLUSTER_COUNT, cc);
        write_fat_register(REG_SECTORS_PER, spc);
        write_fat_register(REG_DATA_START, dss);
    endtask

    // ------------------------------------------------------------------
    // Response side: random back-pressure and the scoreboard
    // ------------------------------------------------------------------

    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_fat_responses.size() == 0)
            begin
                $display("%0t: response word with none expected: status %0d cluster %h sector %h",
                         $time, status, cluster_result, sector_address);
                mismatch_count++;
            end
            else
            begin
                want = expected_fat_responses.pop_front();
                words_checked++;
                if (want.rsp_status == ST_FULL)
                    full_count++;
                if (want.rsp_status == ST_RANGE)
                    range_count++;
                if (status !== want.rsp_status)
                begin
                    $display("%0t: status: expected %0d, actual %0d",
                             $time, want.rsp_status, status);
                    mismatch_count++;
                end
                if (cluster_result !== want.next_cl)
                begin
                    $display("%0t: cluster_result: expected %h, actual %h",
                             $time, want.next_cl, cluster_result);
                    mismatch_count++;
                end
                if (sector_address !== want.sector)
                begin
                    $display("%0t: sector_address: expected %h, actual %h",
                             $time, want.sector, sector_address);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------

    // Top of the busy part of the table: the allocation window plus a little
    function automatic int region_top();
        int hi;
        hi = cc_mirror + 8;
        if (hi > TABLE_ENTRIES - 1)
            hi = TABLE_ENTRIES - 1;
        return hi;
    endfunction

    // Mostly clusters near the allocation window, some anywhere in the table,
    // some anywhere in 28 bits (nearly always outside the table)
    function automatic logic [27:0] rand_cluster();
        int          pick;
        logic [31:0] raw;
        pick = $urandom_range(99);
        raw  = $urandom;
        if (pick < 55)
            return 28'($urandom_range(0, region_top()));
        else if (pick < 80)
            return 28'($urandom_range(0, TABLE_ENTRIES - 1));
        return raw[27:0];
    endfunction

    function automatic logic [31:0] rand_entry_value();
        int          pick;
        logic [31:0] v;
        pick = $urandom_range(99);
        v    = $urandom;
        if (pick < 30)
            v[27:0] = 28'($urandom_range(0, region_top()));
        else if (pick < 50)
            v = '0;
        else if (pick < 60)
            v[27:0] = EOC_MIN | 28'($urandom_range(0, 7));
        return v;
    endfunction

    // Well-formed use: allocate a few clusters, link them into a chain with
    // one of several kinds of tail, look along it, then usually free it
    task automatic run_chain_sequence();
        logic [27:0] links [$];
        fat_resp_t   r;
        logic [31:0] v;
        int          k;
        int          i;
        int          pick;
        k = $urandom_range(1, 6);
        for (i = 0; i < k; i++)
        begin
            send_word(OP_ALLOC, rand_cluster(), $urandom, r);
            if (r.rsp_status == ST_OK)
                links.push_back(r.next_cl);
        end
        if (links.size() == 0)
            return;
        for (i = 0; i + 1 < links.size(); i++)
        begin
            v       = $urandom;      // upper nibble is don't-care on a link
            v[27:0] = links[i + 1];
            send_word(OP_SET, links[i], v, r);
        end
        v    = $urandom;
        pick = $urandom_range(0, 4);
        if (pick != 0)
        begin
            // pick 0 keeps the end mark written by allocate
            case (pick)
                1: v[27:0] = EOC_MIN | 28'($urandom_range(0, 7));
                2: v[27:0] = 28'($urandom_range(0, 1));
                3: v[27:0] = 28'($urandom_range(TABLE_ENTRIES, 28'h0FFFFFF7));
                default: v[27:0] = links[0];   // loop back to the head
            endcase
            send_word(OP_SET, links[links.size() - 1], v, r);
        end
        k = $urandom_range(0, 2);
        for (i = 0; i < k; i++)
            send_word(OP_LOOKUP, links[$urandom_range(0, links.size() - 1)], $urandom, r);
        pick = $urandom_range(0, 9);
        if (pick < 7)
            send_word(OP_FREE, links[0], $urandom, r);
        else if (pick < 9)
            send_word(OP_FREE, links[$urandom_range(0, links.size() - 1)], $urandom, r);
        // otherwise the chain stays allocated and the window slowly fills
    endtask

    task automatic random_single_word();
        fat_resp_t r;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 30)
            send_word(OP_LOOKUP, rand_cluster(), $urandom, r);
        else if (pick < 60)
            send_word(OP_SET, rand_cluster(), rand_entry_value(), r);
        else if (pick < 80)
            send_word(OP_ALLOC, rand_cluster(), $urandom, r);
        else
            send_word(OP_FREE, rand_cluster(), $urandom, r);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register reset values, an empty table, and the table's edges
    task automatic test_reset_state();
        fat_resp_t r;
        check_fat_register(REG_CLUSTER_COUNT);
        check_fat_register(REG_SECTORS_PER);
        check_fat_register(REG_DATA_START);
        // these wait out the clearing sweep on req_ready
        send_word(OP_LOOKUP, 28'd0, 32'hFFFF_FFFF, r);
        send_word(OP_LOOKUP, 28'(TABLE_ENTRIES - 1), 32'd0, r);
        send_word(OP_LOOKUP, 28'(TABLE_ENTRIES), 32'd0, r);
        send_word(OP_LOOKUP, 28'h0FFF_FFFF, 32'hFFFF_FFFF, r);
    endtask

    // Set and lookup at the extremes, masking of the top nibble
    task automatic test_entry_access();
        fat_resp_t r;
        send_word(OP_SET, 28'd1, 32'hFFFF_FFFF, r);
        send_word(OP_LOOKUP, 28'd1, 32'd0, r);
        send_word(OP_SET, 28'h0ABC_DEF0, 32'h1234_5678, r);
        // top nibble only: still counts as free, so allocate takes it
        send_word(OP_SET, 28'd2, 32'hF000_0000, r);
        send_word(OP_ALLOC, 28'h0FFF_FFFF, 32'hFFFF_FFFF, r);
    endtask

    // Chain walks: one that runs off the table part-way, and every end condition
    task automatic test_chain_free();
        fat_resp_t r;
        send_word(OP_ALLOC, 28'd0, 32'd0, r);
        send_word(OP_ALLOC, 28'd0, 32'd0, r);
        send_word(OP_SET, 28'd2, 32'hF000_0003, r);
        send_word(OP_SET, 28'd3, 32'd4, r);
        send_word(OP_SET, 28'd4, 32'd5000, r);
        send_word(OP_FREE, 28'd2, 32'd0, r);          // clears 2,3,4 then out of table
        send_word(OP_LOOKUP, 28'd3, 32'd0, r);
        send_word(OP_FREE, 28'd0, 32'd0, r);
        send_word(OP_FREE, 28'd1, 32'd0, r);
        send_word(OP_FREE, EOC_MIN, 32'd0, r);
        send_word(OP_FREE, 28'h0FFF_FFFF, 32'd0, r);
        send_word(OP_FREE, 28'(TABLE_ENTRIES), 32'd0, r);
        send_word(OP_ALLOC, 28'd0, 32'd0, r);
        send_word(OP_FREE, r.next_cl, 32'd0, r);      // plain chain of one, end mark
    endtask

    // Allocation window at its limits, address wrap, register width masking
    task automatic test_alloc_limits();
        fat_resp_t r;
        configure_table(32'd1, 32'd128, 32'hFFFF_FFFF);
        send_word(OP_ALLOC, 28'd0, 32'd0, r);
        send_word(OP_ALLOC, 28'd0, 32'd0, r);          // window of one is now full
        send_word(OP_LOOKUP, 28'd0, 32'd0, r);
        wait_drained();
        write_fat_register(REG_CLUSTER_COUNT, 32'd0);   // empty window
        send_word(OP_ALLOC, 28'd0, 32'd0, r);
        wait_drained();
        write_fat_register(REG_CLUSTER_COUNT, 32'hFFFF_FFFF);
        write_fat_register(REG_SECTORS_PER, 32'h1234_5600);
        send_word(OP_ALLOC, 28'd0, 32'd0, r);
    endtask

    task automatic test_random_traffic(input int n_words);
        int first;
        first = words_sent;
        while (words_sent - first < n_words)
        begin
            if ($urandom_range(99) < 35)
                run_chain_sequence();
            else
                random_single_word();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
            fat_mirror[i] = '0;
        send_idle_pct = 27;
        recv_idle_pct = 74;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_entry_access();
        test_chain_free();
        test_alloc_limits();

        // Small window, widest clusters, start sector at the top: fills up often
        configure_table(32'd64, 32'd128, 32'hFFFF_FFFF);
        test_random_traffic(560);

        // Full-size window, reset-value geometry, idling swapped
        configure_table(32'd4094, 32'd1, 32'd0);
        send_idle_pct = 74;
        recv_idle_pct = 27;
        test_random_traffic(560);

        // Random geometry, both sides flat out
        configure_table($urandom_range(1, 300), $urandom_range(1, 128), $urandom);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(560);

        wait_drained();
        $display("Covered %0d request words: %0d lookup, %0d set, %0d allocate, %0d free.",
                 words_sent, op_count[OP_LOOKUP], op_count[OP_SET], op_count[OP_ALLOC],
                 op_count[OP_FREE]);
        $display("Checked %0d response words, %0d with a full table and %0d outside the table.",
                 words_checked, full_count, range_count);
        if (mismatch_count == 0 && expected_fat_responses.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Ceiling well above the slowest legal run, clearing sweep included
    initial
    begin
        #600_000_000;
        $display("Timeout with %0d response words outstanding", expected_fat_responses.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
